// File: hdl/cpsd_pkg.sv
package cpsd_pkg;

	localparam int MAX_NEST_DEPTH   = 16;
	localparam int MAX_VARINT_BYTES = 10;
	localparam int SP_W             = $clog2(MAX_NEST_DEPTH + 1);
	localparam int IDX_W            = $clog2(MAX_NEST_DEPTH);
	localparam int NEST_W           = 5;

	localparam logic [7:0] MAGIC_BYTE  = 8'h82;
	localparam logic [4:0] VER_MIN     = 5'd1;
	localparam logic [4:0] VER_MAX     = 5'd2;
	localparam logic [2:0] MSG_REPLY     = 3'd2;
	localparam logic [2:0] MSG_EXCEPTION = 3'd3;

	// Compact type codes.
	localparam logic [3:0] CT_STOP   = 4'd0;
	localparam logic [3:0] CT_TRUE   = 4'd1;
	localparam logic [3:0] CT_FALSE  = 4'd2;
	localparam logic [3:0] CT_BYTE   = 4'd3;
	localparam logic [3:0] CT_I16    = 4'd4;
	localparam logic [3:0] CT_I32    = 4'd5;
	localparam logic [3:0] CT_I64    = 4'd6;
	localparam logic [3:0] CT_DOUBLE = 4'd7;
	localparam logic [3:0] CT_BINARY = 4'd8;
	localparam logic [3:0] CT_LIST   = 4'd9;
	localparam logic [3:0] CT_SET    = 4'd10;
	localparam logic [3:0] CT_MAP    = 4'd11;
	localparam logic [3:0] CT_STRUCT = 4'd12;
	localparam logic [3:0] CT_FLOAT  = 4'd13;
	localparam logic [3:0] LONG_LIST = 4'd15;

	// Token kinds.
	localparam logic [3:0] TK_HEADER  = 4'd0;
	localparam logic [3:0] TK_FIELD   = 4'd1;
	localparam logic [3:0] TK_SEND    = 4'd2;
	localparam logic [3:0] TK_INT     = 4'd3;
	localparam logic [3:0] TK_BYTE    = 4'd4;
	localparam logic [3:0] TK_BOOL    = 4'd5;
	localparam logic [3:0] TK_DOUBLE  = 4'd6;
	localparam logic [3:0] TK_FLOAT   = 4'd7;
	localparam logic [3:0] TK_STRLEN  = 4'd8;
	localparam logic [3:0] TK_STRBYTE = 4'd9;
	localparam logic [3:0] TK_LIST    = 4'd10;
	localparam logic [3:0] TK_MAP     = 4'd11;
	localparam logic [3:0] TK_CEND    = 4'd12;
	localparam logic [3:0] TK_ERROR   = 4'd13;

	// Error codes.
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_PROTO    = 3'd1;
	localparam logic [2:0] ERR_VERSION  = 3'd2;
	localparam logic [2:0] ERR_RESPONSE = 3'd3;
	localparam logic [2:0] ERR_TYPE     = 3'd4;
	localparam logic [2:0] ERR_VARINT   = 3'd5;
	localparam logic [2:0] ERR_DEPTH    = 3'd6;

	// Frame kinds.
	localparam logic [1:0] FR_STRUCT = 2'd0;
	localparam logic [1:0] FR_LIST   = 2'd1;
	localparam logic [1:0] FR_MAP    = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_t;

	typedef struct packed {
		logic [3:0]         token_kind;
		logic signed [15:0] field_id;
		logic [3:0]         type_code;
		logic [3:0]         key_type;
		logic signed [63:0] token_value;
		logic [4:0]         nest_level;
		logic [2:0]         message_kind;
		logic [2:0]         error_code;
		logic               message_end;
		logic               last_of_run;
	} token_t;

	// A classified input byte as it waits between front and back.
	typedef struct packed {
		logic [7:0] data;
		logic       restart;
		logic [3:0] lo;
		logic [3:0] hi;
		logic       lo_bad;
		logic       hi_bad;
		logic       more;
	} cbyte_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] count;
		logic [15:0] last_fid;
		logic [3:0]  ktype;
		logic [3:0]  vtype;
		logic        second;
	} frame_t;

	function automatic frame_t advance(input frame_t f);
		frame_t r;
		r = f;
		if (f.kind == FR_MAP && !f.second) begin
			r.second = 1'b1;
		end else begin
			r.second = 1'b0;
			r.count  = f.count - 32'd1;
		end
		return r;
	endfunction

	function automatic logic [63:0] unzigzag(input logic [63:0] n);
		return (n >> 1) ^ {64{n[0]}};
	endfunction

endpackage

// File: hdl/cpsd_front.sv
module cpsd_front import cpsd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   byte_valid,
	output logic   byte_ready,
	input  in_t    byte_data,
	output logic   q_valid,
	input  logic   q_pop,
	output cbyte_t q_data
);

	cbyte_t     fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cbyte_t     cls;
	logic       push;

	always_comb begin
		cls.data    = byte_data.data_byte;
		cls.restart = byte_data.restart;
		cls.lo      = byte_data.data_byte[3:0];
		cls.hi      = byte_data.data_byte[7:4];
		cls.lo_bad  = byte_data.data_byte[3:0] > CT_FLOAT;
		cls.hi_bad  = byte_data.data_byte[7:4] > CT_FLOAT;
		cls.more    = byte_data.data_byte[7];
	end

	assign byte_ready = (cnt_q != 2'd2);
	assign push       = byte_valid && byte_ready;
	assign q_valid    = (cnt_q != 2'd0);
	assign q_data     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

endmodule

// File: hdl/cpsd_back.sv
module cpsd_back import cpsd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	output logic   q_pop,
	input  cbyte_t q_data,
	output logic   token_valid,
	input  logic   token_ready,
	output token_t token_data
);

	typedef enum logic [18:0] {
		PH_PROTO     = 19'h00001,
		PH_VER       = 19'h00002,
		PH_SEQ       = 19'h00004,
		PH_NAMELEN   = 19'h00008,
		PH_NAMEBYTES = 19'h00010,
		PH_FIELD     = 19'h00020,
		PH_FIELDID   = 19'h00040,
		PH_BOOLBYTE  = 19'h00080,
		PH_BYTE      = 19'h00100,
		PH_INT       = 19'h00200,
		PH_RAW       = 19'h00400,
		PH_STRLEN    = 19'h00800,
		PH_STRBYTES  = 19'h01000,
		PH_LISTHDR   = 19'h02000,
		PH_LISTSIZE  = 19'h04000,
		PH_MAPSIZE   = 19'h08000,
		PH_MAPTYPES  = 19'h10000,
		PH_DONE      = 19'h20000,
		PH_ERROR     = 19'h40000
	} phase_t;

	typedef enum logic [6:0] {
		S_FETCH    = 7'h01,
		S_BYTE     = 7'h02,
		S_FIELD2   = 7'h04,
		S_NAMEDONE = 7'h08,
		S_VDONE    = 7'h10,
		S_SEEK     = 7'h20,
		S_FLUSH    = 7'h40
	} seq_t;

	seq_t        st_q, st_n;
	phase_t      ph_q, ph_n;
	logic [SP_W-1:0] sp_q, sp_n, sp_m1;
	logic [63:0] acc_q, acc_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [31:0] rem_q, rem_n;
	logic [63:0] raw_q, raw_n;
	logic [4:0]  wv_q, wv_n;
	logic [2:0]  hdr_q, hdr_n;
	logic [3:0]  pend_q, pend_n;
	cbyte_t      byte_q;
	frame_t      stk_q [MAX_NEST_DEPTH];

	token_t hold_q, out_q, gt, flush_tok;
	logic   hold_v_q, out_v_q;
	logic   gen, out_free, can_gen, flush_out;

	frame_t             top, wr_fr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic               full;

	// Varint step.
	logic [6:0]  sh;
	logic [63:0] acc_feed;
	logic [3:0]  cnt_inc;
	logic        v_done, v_over;

	logic        do_err, do_cb, do_fh, do_bv;
	logic [2:0]  err_c;
	logic [1:0]  cb_kind;
	logic [31:0] cb_cnt;
	logic [3:0]  cb_kt, cb_vt, bv_t, el_t;
	logic [15:0] fh_fid;
	logic        el_zero;

	assign sp_m1    = sp_q - SP_W'(1);
	assign top      = stk_q[sp_m1[IDX_W-1:0]];
	assign full     = sp_q >= SP_W'(MAX_NEST_DEPTH);
	assign out_free = !out_v_q || token_ready;
	assign can_gen  = !hold_v_q || out_free;

	assign sh       = {cnt_q, 3'b000} - {3'b000, cnt_q};
	assign acc_feed = acc_q | ({57'd0, byte_q.data[6:0]} << sh);
	assign v_done   = !byte_q.more;
	assign cnt_inc  = cnt_q + 4'd1;
	assign v_over   = cnt_inc >= 4'(MAX_VARINT_BYTES);

	assign el_zero = (top.count == 32'd0) ||
		(top.kind == FR_LIST && top.vtype == CT_STOP) ||
		(top.kind == FR_MAP && top.ktype == CT_STOP && top.vtype == CT_STOP);
	assign el_t = (top.kind == FR_MAP && !top.second) ? top.ktype : top.vtype;

	assign token_valid = out_v_q;
	assign token_data  = out_q;

	always_comb begin
		flush_tok = hold_q;
		flush_tok.last_of_run = flush_out;
	end

	always_comb begin
		st_n   = st_q;
		ph_n   = ph_q;
		sp_n   = sp_q;
		acc_n  = acc_q;
		cnt_n  = cnt_q;
		rem_n  = rem_q;
		raw_n  = raw_q;
		wv_n   = wv_q;
		hdr_n  = hdr_q;
		pend_n = pend_q;
		gen    = 1'b0;
		gt     = '0;
		gt.nest_level = NEST_W'(sp_q);
		wr_en  = 1'b0;
		wr_idx = sp_m1[IDX_W-1:0];
		wr_fr  = top;
		q_pop  = 1'b0;
		flush_out = 1'b0;
		do_err = 1'b0;
		err_c  = ERR_NONE;
		do_cb  = 1'b0;
		cb_kind = FR_LIST;
		cb_cnt = 32'd0;
		cb_kt  = CT_STOP;
		cb_vt  = CT_STOP;
		do_fh  = 1'b0;
		fh_fid = 16'd0;
		do_bv  = 1'b0;
		bv_t   = pend_q;

		unique case (st_q)
			S_FETCH: begin
				if (q_valid) begin
					q_pop = 1'b1;
					st_n  = S_BYTE;
					if (q_data.restart) begin
						ph_n   = PH_PROTO;
						sp_n   = '0;
						acc_n  = '0;
						cnt_n  = '0;
						rem_n  = '0;
						raw_n  = '0;
						wv_n   = VER_MAX;
						hdr_n  = '0;
						pend_n = '0;
					end
				end
			end
			S_BYTE: begin
				st_n = S_FLUSH;
				unique case (ph_q)
					PH_PROTO: begin
						if (byte_q.data != MAGIC_BYTE) begin
							do_err = 1'b1;
							err_c  = ERR_PROTO;
						end else begin
							ph_n = PH_VER;
						end
					end
					PH_VER: begin
						hdr_n = byte_q.data[7:5];
						wv_n  = byte_q.data[4:0];
						if (byte_q.data[4:0] < VER_MIN || byte_q.data[4:0] > VER_MAX) begin
							do_err = 1'b1;
							err_c  = ERR_VERSION;
						end else begin
							acc_n = '0;
							cnt_n = '0;
							ph_n  = PH_SEQ;
						end
					end
					PH_SEQ, PH_NAMELEN, PH_FIELDID, PH_INT, PH_STRLEN,
					PH_LISTSIZE, PH_MAPSIZE: begin
						acc_n = acc_feed;
						if (!v_done) begin
							cnt_n = cnt_inc;
							if (v_over) begin
								do_err = 1'b1;
								err_c  = ERR_VARINT;
							end
						end else begin
							priority case (1'b1)
								ph_q == PH_SEQ: begin
									gen = 1'b1;
									gt.token_kind  = TK_HEADER;
									gt.token_value = acc_feed;
									acc_n = '0;
									cnt_n = '0;
									ph_n  = PH_NAMELEN;
								end
								ph_q == PH_NAMELEN || ph_q == PH_STRLEN: begin
									rem_n = acc_feed[31:0];
									gen = 1'b1;
									gt.token_kind  = TK_STRLEN;
									gt.type_code   = CT_BINARY;
									gt.token_value = {32'd0, acc_feed[31:0]};
									if (acc_feed[31:0] == 32'd0) begin
										st_n = (ph_q == PH_NAMELEN) ? S_NAMEDONE : S_VDONE;
									end else begin
										ph_n = (ph_q == PH_NAMELEN) ? PH_NAMEBYTES : PH_STRBYTES;
									end
								end
								ph_q == PH_FIELDID: begin
									do_fh  = 1'b1;
									fh_fid = 16'(unzigzag(acc_feed));
								end
								ph_q == PH_INT: begin
									gen = 1'b1;
									gt.token_kind  = TK_INT;
									gt.type_code   = pend_q;
									gt.token_value = unzigzag(acc_feed);
									st_n = S_VDONE;
								end
								ph_q == PH_LISTSIZE: begin
									do_cb   = 1'b1;
									cb_kind = FR_LIST;
									cb_cnt  = acc_feed[31:0];
									cb_vt   = pend_q;
								end
								default: begin
									rem_n = acc_feed[31:0];
									if (acc_feed[31:0] == 32'd0) begin
										do_cb   = 1'b1;
										cb_kind = FR_MAP;
									end else begin
										ph_n = PH_MAPTYPES;
									end
								end
							endcase
						end
					end
					PH_NAMEBYTES, PH_STRBYTES: begin
						gen = 1'b1;
						gt.token_kind  = TK_STRBYTE;
						gt.type_code   = CT_BINARY;
						gt.token_value = {56'd0, byte_q.data};
						rem_n = rem_q - 32'd1;
						if (rem_q == 32'd1) begin
							st_n = (ph_q == PH_NAMEBYTES) ? S_NAMEDONE : S_VDONE;
						end
					end
					PH_FIELD: begin
						if (byte_q.lo_bad) begin
							do_err = 1'b1;
							err_c  = ERR_TYPE;
						end else if (byte_q.lo == CT_STOP) begin
							sp_n = sp_m1;
							gen  = 1'b1;
							gt.token_kind  = TK_SEND;
							gt.nest_level  = NEST_W'(sp_m1);
							gt.message_end = (sp_m1 == '0);
							st_n = S_VDONE;
						end else begin
							pend_n = byte_q.lo;
							if (byte_q.hi == 4'd0) begin
								acc_n = '0;
								cnt_n = '0;
								ph_n  = PH_FIELDID;
							end else begin
								do_fh  = 1'b1;
								fh_fid = top.last_fid + {12'd0, byte_q.hi};
							end
						end
					end
					PH_BOOLBYTE: begin
						gen = 1'b1;
						gt.token_kind  = TK_BOOL;
						gt.type_code   = pend_q;
						gt.token_value = {63'd0, byte_q.data == 8'd1};
						st_n = S_VDONE;
					end
					PH_BYTE: begin
						gen = 1'b1;
						gt.token_kind  = TK_BYTE;
						gt.type_code   = CT_BYTE;
						gt.token_value = {{56{byte_q.data[7]}}, byte_q.data};
						st_n = S_VDONE;
					end
					PH_RAW: begin
						if (pend_q == CT_FLOAT || wv_q >= VER_MAX) begin
							raw_n = {raw_q[55:0], byte_q.data};
						end else begin
							raw_n = {byte_q.data, raw_q[63:8]};
						end
						rem_n = rem_q - 32'd1;
						if (rem_q == 32'd1) begin
							gen = 1'b1;
							gt.token_kind  = (pend_q == CT_DOUBLE) ? TK_DOUBLE : TK_FLOAT;
							gt.type_code   = pend_q;
							gt.token_value = raw_n;
							st_n = S_VDONE;
						end
					end
					PH_LISTHDR: begin
						if (byte_q.lo_bad) begin
							do_err = 1'b1;
							err_c  = ERR_TYPE;
						end else if (byte_q.hi == LONG_LIST) begin
							pend_n = byte_q.lo;
							acc_n  = '0;
							cnt_n  = '0;
							ph_n   = PH_LISTSIZE;
						end else begin
							do_cb   = 1'b1;
							cb_kind = FR_LIST;
							cb_cnt  = {28'd0, byte_q.hi};
							cb_vt   = byte_q.lo;
						end
					end
					PH_MAPTYPES: begin
						if (byte_q.lo_bad || byte_q.hi_bad) begin
							do_err = 1'b1;
							err_c  = ERR_TYPE;
						end else begin
							do_cb   = 1'b1;
							cb_kind = FR_MAP;
							cb_cnt  = rem_q;
							cb_kt   = byte_q.hi;
							cb_vt   = byte_q.lo;
						end
					end
					default: begin
					end
				endcase
			end
			S_FIELD2: begin
				if (can_gen) begin
					st_n = S_FLUSH;
					if (pend_q == CT_TRUE || pend_q == CT_FALSE) begin
						gen = 1'b1;
						gt.token_kind  = TK_BOOL;
						gt.type_code   = pend_q;
						gt.token_value = {63'd0, pend_q == CT_TRUE};
						st_n = S_VDONE;
					end else begin
						do_bv = 1'b1;
						bv_t  = pend_q;
					end
				end
			end
			S_NAMEDONE: begin
				if (can_gen) begin
					st_n = S_FLUSH;
					if (hdr_q != MSG_REPLY && hdr_q != MSG_EXCEPTION) begin
						do_err = 1'b1;
						err_c  = ERR_RESPONSE;
					end else begin
						wr_en  = 1'b1;
						wr_idx = sp_q[IDX_W-1:0];
						wr_fr  = '0;
						wr_fr.kind = FR_STRUCT;
						sp_n = sp_q + SP_W'(1);
						ph_n = PH_FIELD;
					end
				end
			end
			S_VDONE: begin
				if (sp_q == '0) begin
					ph_n = PH_DONE;
					st_n = S_FLUSH;
				end else if (top.kind == FR_STRUCT) begin
					ph_n = PH_FIELD;
					st_n = S_FLUSH;
				end else begin
					wr_en = 1'b1;
					wr_fr = advance(top);
					st_n  = S_SEEK;
				end
			end
			S_SEEK: begin
				if (can_gen) begin
					if (el_zero) begin
						sp_n = sp_m1;
						gen  = 1'b1;
						gt.token_kind = TK_CEND;
						gt.nest_level = NEST_W'(sp_m1);
						st_n = S_VDONE;
					end else if (el_t != CT_STOP) begin
						do_bv = 1'b1;
						bv_t  = el_t;
						st_n  = S_FLUSH;
					end else begin
						// A stop-typed key or value takes no bytes; skip over it.
						wr_en = 1'b1;
						wr_fr = advance(top);
					end
				end
			end
			S_FLUSH: begin
				if (!hold_v_q) begin
					st_n = S_FETCH;
				end else if (out_free) begin
					flush_out = 1'b1;
					st_n = S_FETCH;
				end
			end
			default: begin
				st_n = S_FETCH;
			end
		endcase

		if (do_fh) begin
			wr_en = 1'b1;
			wr_fr = top;
			wr_fr.last_fid = fh_fid;
			gen = 1'b1;
			gt.token_kind = TK_FIELD;
			gt.field_id   = fh_fid;
			gt.type_code  = pend_n;
			st_n = S_FIELD2;
		end

		if (do_cb) begin
			if (full) begin
				do_err = 1'b1;
				err_c  = ERR_DEPTH;
			end else begin
				gen = 1'b1;
				gt.token_kind  = (cb_kind == FR_LIST) ? TK_LIST : TK_MAP;
				gt.type_code   = cb_vt;
				gt.key_type    = cb_kt;
				gt.token_value = {32'd0, cb_cnt};
				wr_en  = 1'b1;
				wr_idx = sp_q[IDX_W-1:0];
				wr_fr.kind     = cb_kind;
				wr_fr.count    = cb_cnt;
				wr_fr.last_fid = '0;
				wr_fr.ktype    = cb_kt;
				wr_fr.vtype    = cb_vt;
				wr_fr.second   = 1'b0;
				sp_n = sp_q + SP_W'(1);
				st_n = S_SEEK;
			end
		end

		if (do_bv) begin
			pend_n = bv_t;
			unique case (bv_t)
				CT_TRUE, CT_FALSE: ph_n = PH_BOOLBYTE;
				CT_BYTE: ph_n = PH_BYTE;
				CT_I16, CT_I32, CT_I64: begin
					acc_n = '0;
					cnt_n = '0;
					ph_n  = PH_INT;
				end
				CT_DOUBLE: begin
					raw_n = '0;
					rem_n = 32'd8;
					ph_n  = PH_RAW;
				end
				CT_FLOAT: begin
					raw_n = '0;
					rem_n = 32'd4;
					ph_n  = PH_RAW;
				end
				CT_BINARY: begin
					acc_n = '0;
					cnt_n = '0;
					ph_n  = PH_STRLEN;
				end
				CT_LIST, CT_SET: ph_n = PH_LISTHDR;
				CT_MAP: begin
					acc_n = '0;
					cnt_n = '0;
					ph_n  = PH_MAPSIZE;
				end
				default: begin
					// Nested struct: pushes a frame, no token of its own.
					if (full) begin
						do_err = 1'b1;
						err_c  = ERR_DEPTH;
					end else begin
						wr_en  = 1'b1;
						wr_idx = sp_q[IDX_W-1:0];
						wr_fr  = '0;
						wr_fr.kind = FR_STRUCT;
						sp_n = sp_q + SP_W'(1);
						ph_n = PH_FIELD;
					end
				end
			endcase
		end

		if (do_err) begin
			gen = 1'b1;
			gt  = '0;
			gt.token_kind = TK_ERROR;
			gt.error_code = err_c;
			gt.nest_level = NEST_W'(sp_q);
			wr_en = 1'b0;
			sp_n  = sp_q;
			ph_n  = PH_ERROR;
			st_n  = S_FLUSH;
		end

		gt.message_kind = hdr_n;
		gt.last_of_run  = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q <= q_data;
		end
		if (wr_en) begin
			stk_q[wr_idx] <= wr_fr;
		end
		if (gen) begin
			hold_q <= gt;
		end
		if ((gen && hold_v_q) || flush_out) begin
			out_q <= flush_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_FETCH;
			ph_q     <= PH_PROTO;
			sp_q     <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			rem_q    <= '0;
			raw_q    <= '0;
			wv_q     <= VER_MAX;
			hdr_q    <= '0;
			pend_q   <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			st_q   <= st_n;
			ph_q   <= ph_n;
			sp_q   <= sp_n;
			acc_q  <= acc_n;
			cnt_q  <= cnt_n;
			rem_q  <= rem_n;
			raw_q  <= raw_n;
			wv_q   <= wv_n;
			hdr_q  <= hdr_n;
			pend_q <= pend_n;
			if (gen) begin
				hold_v_q <= 1'b1;
			end else if (flush_out) begin
				hold_v_q <= 1'b0;
			end
			if ((gen && hold_v_q) || flush_out) begin
				out_v_q <= 1'b1;
			end else if (token_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/compact_protocol_stream_decoder.sv
// Each byte passes through fetch, execute and flush of the last token in the decoder,
// plus further states for extra tokens and per step of a container end or value-done unwind.
// The back sequencer sets the pace and fetches no new byte until it is done with the last one.
// A two-entry byte queue in front keeps the input accepting while the back end works.
// Asynchronous reset clears the parser, the queue and the output; stack frames are not cleared.
module compact_protocol_stream_decoder import cpsd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   byte_valid,
	output logic   byte_ready,
	input  in_t    byte_data,
	output logic   token_valid,
	input  logic   token_ready,
	output token_t token_data
);

	logic   q_valid;
	logic   q_pop;
	cbyte_t q_data;

	cpsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_data     (q_data)
	);

	cpsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_data),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_data  (token_data)
	);

endmodule
